FILE: hw/rtl/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types, constants and the angle table of the cylindrical bin envelope.
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int CNT_W   = 7;   // layer / sector count register width
  localparam int MH_W    = 31;  // max height / thickness width
  localparam int DIST_W  = 32;
  localparam int IDX_W   = 6;   // result index width
  localparam int PADDR_W = 4;

  localparam int DEF_MAX_LAYERS  = 64;
  localparam int DEF_MAX_SECTORS = 64;

  localparam logic [1:0] REG_LAYER_COUNT  = 2'd0;
  localparam logic [1:0] REG_SECTOR_COUNT = 2'd1;
  localparam logic [1:0] REG_MAX_HEIGHT   = 2'd2;

  localparam logic [CNT_W-1:0] DEF_LAYER_COUNT  = 7'd8;
  localparam logic [CNT_W-1:0] DEF_SECTOR_COUNT = 7'd8;
  localparam logic [MH_W-1:0]  DEF_MAX_HEIGHT   = 31'd655360;

  localparam int CORDIC_STEPS = 18;
  localparam int ACC_W        = 25;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = MH_W + CNT_W;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_ACCUM  = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    F_IDLE, F_PREP, F_NORM, F_RUN, F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_INIT, B_IDLE, B_SWEEP, B_RD, B_WR, B_QRY, B_OUT
  } back_state_e;

  // classified request handed from front to back
  typedef struct packed {
    mode_e              mode;
    logic [CNT_W-1:0]   layer;
    logic [CNT_W-1:0]   sector;
    logic [CNT_W-1:0]   scnt;
    logic [DIST_W-1:0]  radial;
    logic [DIST_W-1:0]  reach;
    logic               reach_ok;
    logic               y_ok;
  } work_t;

  typedef struct packed {
    logic               inside_res;
    logic [IDX_W-1:0]   layer_index;
    logic [IDX_W-1:0]   sector_index;
    logic [DIST_W-1:0]  radial_distance;
  } result_t;

  // atan(2^-i) in units of 2^-24 turn
  function automatic logic [ACC_W-1:0] turn_step(input logic [4:0] i);
    logic [ACC_W-1:0] r;
    case (i)
      5'd0:    r = 25'd2097152;
      5'd1:    r = 25'd1238021;
      5'd2:    r = 25'd654136;
      5'd3:    r = 25'd332050;
      5'd4:    r = 25'd166669;
      5'd5:    r = 25'd83416;
      5'd6:    r = 25'd41718;
      5'd7:    r = 25'd20860;
      5'd8:    r = 25'd10430;
      5'd9:    r = 25'd5215;
      5'd10:   r = 25'd2608;
      5'd11:   r = 25'd1304;
      5'd12:   r = 25'd652;
      5'd13:   r = 25'd326;
      5'd14:   r = 25'd163;
      5'd15:   r = 25'd81;
      5'd16:   r = 25'd41;
      5'd17:   r = 25'd20;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/cbe_fifo.sv
// ----------------------------------------------------------------------------
// cbe_fifo
// Small register queue with full/empty flags.
// ----------------------------------------------------------------------------
module cbe_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

FILE: hw/rtl/cbe_front.sv
// ----------------------------------------------------------------------------
// cbe_front
// Takes one point, finds its layer (serial divide), sector (CORDIC) and
// radial distance (serial root), and queues the classified request.
// ----------------------------------------------------------------------------
module cbe_front #(
  parameter int MAX_LAYERS  = cbe_pkg::DEF_MAX_LAYERS,
  parameter int MAX_SECTORS = cbe_pkg::DEF_MAX_SECTORS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [1:0]                 mode_i,
  input  logic signed [31:0]         pos_x_i,
  input  logic signed [31:0]         pos_y_i,
  input  logic signed [31:0]         pos_z_i,
  input  logic [cbe_pkg::MH_W-1:0]   thickness_i,
  input  logic [cbe_pkg::CNT_W-1:0]  layer_count_i,
  input  logic [cbe_pkg::CNT_W-1:0]  sector_count_i,
  input  logic [cbe_pkg::MH_W-1:0]   max_height_i,
  output logic                       busy_o,
  output cbe_pkg::work_t             work_o,
  output logic                       work_push_o,
  input  logic                       work_full_i
);
  import cbe_pkg::*;

  localparam int PQ_W  = 36;
  localparam int DVD_W = DIV_STEPS;

  front_state_e state_q, state_d;
  logic [5:0]   cnt_q, cnt_d;

  logic [1:0]               mode_q;
  logic signed [31:0]       x_q, y_q, z_q;
  logic [MH_W-1:0]          thick_q;
  logic                     axis_q, pi_q, ypos_q, y_ok_q;
  logic [1:0]               base_q;
  logic signed [PQ_W-1:0]   p_q, q_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [63:0]              sqx_q, sqz_q, v_q, res_q;
  logic [DVD_W-1:0]         dvd_q, quo_q;
  logic [MH_W-1:0]          rem_q;

  logic [CNT_W-1:0] lc_eff, sc_eff;

  always_comb begin
    lc_eff = layer_count_i;
    if (layer_count_i == '0) lc_eff = CNT_W'(1);
    else if (32'(layer_count_i) > MAX_LAYERS) lc_eff = CNT_W'(MAX_LAYERS);
    sc_eff = sector_count_i;
    if (sector_count_i == '0) sc_eff = CNT_W'(1);
    else if (32'(sector_count_i) > MAX_SECTORS) sc_eff = CNT_W'(MAX_SECTORS);
  end

  // quadrant reduction of (-z, -x)
  logic signed [32:0] a_s, b_s, p0, q0;
  logic [1:0]         base0;
  logic [31:0]        ax, az;

  assign a_s = -$signed({z_q[31], z_q});
  assign b_s = -$signed({x_q[31], x_q});
  assign ax  = x_q[31] ? (~x_q + 32'd1) : x_q;
  assign az  = z_q[31] ? (~z_q + 32'd1) : z_q;

  always_comb begin
    if (a_s > 0 && b_s >= 0) begin
      base0 = 2'd0; p0 = a_s;  q0 = b_s;
    end else if (a_s <= 0 && b_s > 0) begin
      base0 = 2'd1; p0 = b_s;  q0 = -a_s;
    end else if (a_s < 0 && b_s <= 0) begin
      base0 = 2'd2; p0 = -a_s; q0 = -b_s;
    end else begin
      base0 = 2'd3; p0 = -b_s; q0 = a_s;
    end
  end

  logic norm_done;
  assign norm_done = axis_q || (p_q[PQ_W-1:30] != '0) || (q_q[PQ_W-1:30] != '0);

  // divide step
  logic [MH_W:0]   t_div;
  logic            div_ge;
  logic [MH_W:0]   t_sub;
  assign t_div  = {rem_q, dvd_q[DVD_W-1]};
  assign div_ge = (t_div >= {1'b0, max_height_i});
  assign t_sub  = t_div - {1'b0, max_height_i};

  // root step
  logic [63:0] bit_c, sum_c;
  assign bit_c = 64'h4000_0000_0000_0000 >> {cnt_q[4:0], 1'b0};
  assign sum_c = res_q + bit_c;

  // CORDIC step
  logic signed [PQ_W-1:0]  sp, sq;
  logic signed [ACC_W-1:0] step_c;
  assign sp     = p_q >>> cnt_q[4:0];
  assign sq     = q_q >>> cnt_q[4:0];
  assign step_c = $signed(turn_step(cnt_q[4:0]));

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      F_IDLE: if (accept_i) state_d = F_PREP;
      F_PREP: state_d = F_NORM;
      F_NORM: if (norm_done) state_d = F_RUN;
      F_RUN: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS-1)) begin
          state_d = F_PUSH;
          cnt_d   = '0;
        end
      end
      F_PUSH: if (!work_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (accept_i) begin
          mode_q  <= mode_i;
          x_q     <= pos_x_i;
          y_q     <= pos_y_i;
          z_q     <= pos_z_i;
          thick_q <= thickness_i;
        end
      end
      F_PREP: begin
        sqx_q  <= 64'(ax) * 64'(ax);
        sqz_q  <= 64'(az) * 64'(az);
        dvd_q  <= DVD_W'(y_q[MH_W-1:0]) * DVD_W'(lc_eff);
        quo_q  <= '0;
        rem_q  <= '0;
        res_q  <= '0;
        acc_q  <= '0;
        axis_q <= (x_q == '0) && (z_q == '0);
        pi_q   <= (x_q == '0) && z_q[31];
        ypos_q <= !y_q[31] && (y_q != '0);
        y_ok_q <= y_q[31] || (y_q[MH_W-1:0] <= max_height_i);
        base_q <= base0;
        p_q    <= {{(PQ_W-33){p0[32]}}, p0};
        q_q    <= {{(PQ_W-33){q0[32]}}, q0};
      end
      F_NORM: begin
        v_q <= sqx_q + sqz_q;
        if (!norm_done) begin
          p_q <= p_q <<< 1;
          q_q <= q_q <<< 1;
        end
      end
      F_RUN: begin
        rem_q <= div_ge ? t_sub[MH_W-1:0] : t_div[MH_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], div_ge};
        dvd_q <= dvd_q << 1;
        if (!cnt_q[5]) begin
          if (v_q >= sum_c) begin
            v_q   <= v_q - sum_c;
            res_q <= (res_q >> 1) + bit_c;
          end else begin
            res_q <= res_q >> 1;
          end
        end
        if (cnt_q < 6'(CORDIC_STEPS)) begin
          if (!q_q[PQ_W-1]) begin
            p_q   <= p_q + sq;
            q_q   <= q_q - sp;
            acc_q <= acc_q + step_c;
          end else begin
            p_q   <= p_q - sq;
            q_q   <= q_q + sp;
            acc_q <= acc_q - step_c;
          end
        end
      end
      default: ;
    endcase
  end

  // classification of the finished point
  logic [21:0]        acc_cl;
  logic [15:0]        turn;
  logic [CNT_W+15:0]  ts;
  logic [CNT_W-1:0]   sidx, sector_c, layer_c;
  logic [DIST_W-1:0]  dist_c;
  logic [DIST_W:0]    reach_sum;

  always_comb begin
    if (acc_q[ACC_W-1])                 acc_cl = '0;
    else if (acc_q[ACC_W-2:22] != '0)   acc_cl = '1;
    else                                acc_cl = acc_q[21:0];
    turn = {base_q, acc_cl[21:8]};
    ts   = (CNT_W+16)'(turn) * (CNT_W+16)'(sc_eff);
    sidx = ts[CNT_W+15:16];
    if (axis_q)              sector_c = '0;
    else if (pi_q)           sector_c = sc_eff - 1'b1;
    else if (sidx >= sc_eff) sector_c = sc_eff - 1'b1;
    else                     sector_c = sidx;
    if (!ypos_q)                          layer_c = '0;
    else if (max_height_i == '0)          layer_c = lc_eff - 1'b1;
    else if (quo_q >= DVD_W'(lc_eff))     layer_c = lc_eff - 1'b1;
    else                                  layer_c = quo_q[CNT_W-1:0];
  end

  assign dist_c    = res_q[DIST_W-1:0];
  assign reach_sum = {1'b0, dist_c} + (DIST_W+1)'(thick_q);

  always_comb begin
    work_o.mode     = mode_e'(mode_q);
    work_o.layer    = layer_c;
    work_o.sector   = sector_c;
    work_o.scnt     = sc_eff;
    work_o.radial   = dist_c;
    work_o.reach    = reach_sum[DIST_W] ? '1 : reach_sum[DIST_W-1:0];
    work_o.reach_ok = (dist_c <= DIST_W'(thick_q));
    work_o.y_ok     = y_ok_q;
  end

  assign work_push_o = (state_q == F_PUSH) && !work_full_i;
  assign busy_o      = (state_q != F_IDLE);

endmodule

FILE: hw/rtl/cbe_back.sv
// ----------------------------------------------------------------------------
// cbe_back
// Owns the bin memory: clearing sweeps, read-modify-write updates and
// queries. Builds one result per request.
// ----------------------------------------------------------------------------
module cbe_back #(
  parameter int MAX_LAYERS  = cbe_pkg::DEF_MAX_LAYERS,
  parameter int MAX_SECTORS = cbe_pkg::DEF_MAX_SECTORS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cbe_pkg::work_t   work_i,
  input  logic             work_empty_i,
  output logic             work_pop_o,
  output cbe_pkg::result_t res_o,
  output logic             res_push_o,
  input  logic             res_full_i,
  output logic             init_busy_o
);
  import cbe_pkg::*;

  localparam int DEPTH = MAX_LAYERS * MAX_SECTORS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  back_state_e state_q, state_d;
  work_t       item_q;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [AW-1:0]     swp_q, swp_d;
  logic              ready_q, ready_d;
  logic              inside_q, inside_d;
  logic [DIST_W-1:0] rdata_q;
  logic [DIST_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]  col;
  logic [AW-1:0]     raddr, waddr;
  logic [DIST_W-1:0] upd_val, wdata;
  logic              we, swp_last;

  assign col     = (item_q.mode == MODE_ACCUM && item_q.reach_ok) ? k_q : item_q.sector;
  assign raddr   = AW'(32'(item_q.layer) * MAX_SECTORS + 32'(col));
  assign upd_val = item_q.reach_ok ? item_q.reach : item_q.radial;
  assign swp_last = (swp_q == AW'(DEPTH-1));

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    swp_d      = swp_q;
    ready_d    = ready_q;
    inside_d   = inside_q;
    work_pop_o = 1'b0;
    res_push_o = 1'b0;
    we         = 1'b0;
    waddr      = raddr;
    wdata      = upd_val;
    unique case (state_q)
      B_INIT: begin
        we    = 1'b1;
        waddr = swp_q;
        wdata = '0;
        swp_d = swp_q + 1'b1;
        if (swp_last) begin
          swp_d   = '0;
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!work_empty_i) begin
          work_pop_o = 1'b1;
          inside_d   = 1'b0;
          k_d        = '0;
          swp_d      = '0;
          unique case (work_i.mode)
            MODE_CLEAR:  state_d = B_SWEEP;
            MODE_FINISH: begin
              ready_d = 1'b1;
              state_d = B_OUT;
            end
            MODE_ACCUM:  state_d = B_RD;
            MODE_QUERY:  state_d = B_RD;
            default:     state_d = B_IDLE;
          endcase
        end
      end
      B_SWEEP: begin
        we    = 1'b1;
        waddr = swp_q;
        wdata = '0;
        swp_d = swp_q + 1'b1;
        if (swp_last) begin
          swp_d   = '0;
          ready_d = 1'b0;
          state_d = B_OUT;
        end
      end
      B_RD: state_d = (item_q.mode == MODE_ACCUM) ? B_WR : B_QRY;
      B_WR: begin
        we = (rdata_q < upd_val);
        if (item_q.reach_ok && (k_q != item_q.scnt - 1'b1)) begin
          k_d     = k_q + 1'b1;
          state_d = B_RD;
        end else begin
          state_d = B_OUT;
        end
      end
      B_QRY: begin
        inside_d = !ready_q || ((item_q.radial <= rdata_q) && item_q.y_ok);
        state_d  = B_OUT;
      end
      B_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_INIT;
      k_q      <= '0;
      swp_q    <= '0;
      ready_q  <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      swp_q    <= swp_d;
      ready_q  <= ready_d;
      inside_q <= inside_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_pop_o) item_q <= work_i;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    if (item_q.mode == MODE_CLEAR || item_q.mode == MODE_FINISH) begin
      res_o = '0;
    end else begin
      res_o.inside_res      = inside_q;
      res_o.layer_index     = item_q.layer[IDX_W-1:0];
      res_o.sector_index    = item_q.sector[IDX_W-1:0];
      res_o.radial_distance = item_q.radial;
    end
  end

  assign init_busy_o = (state_q == B_INIT);

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == B_INIT || state_q == B_SWEEP || state_q == B_WR))
    else $error("bin write outside a sweep or update");

  a_upd_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q == B_WR) |-> (wdata > rdata_q))
    else $error("bin update would shrink a bin");

  a_ready_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(work_pop_o && work_i.mode == MODE_FINISH))
    else $error("ready set without a finish request");

  a_sweep_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SWEEP && swp_last) |=> (state_q == B_OUT && !ready_q))
    else $error("clear sweep did not close properly");

endmodule

FILE: hw/rtl/cylindrical_bin_envelope.sv
// ----------------------------------------------------------------------------
// cylindrical_bin_envelope
// Cylindrical envelope built from Q16.16 points binned by height and angle.
//
//   channel   direction  handshake                 payload
//   input     in         push / full               mode, pos_x/y/z, thickness
//   result    out        empty / pop               inside_res, layer/sector,
//                                                  radial_distance
//   config    in/out     psel/penable/pwrite/...   layer_count, sector_count,
//                                                  max_height (0x0, 0x4, 0x8)
//
// Front: per request a prep step, a normalization of the CORDIC operands,
//   the shared step loop (serial divide, root and 18 CORDIC steps) and a
//   hand-off to the queue, which waits while the queue is full.
// Back, after taking a request from the queue: clear sweeps the whole bin
//   memory, then gives its result; accumulate reads and writes back each
//   touched bin (one bin or the whole layer), then gives its result; query
//   reads and compares its bin, then gives its result; finish gives its result.
// After reset the back sweeps the memory to zero (MAX_LAYERS*MAX_SECTORS
//   bins, 4096 by default); full stays high meanwhile.
// A two-entry queue sits between front and back, another on the results,
//   so the front takes new points while the back or the consumer stalls.
// ----------------------------------------------------------------------------
module cylindrical_bin_envelope #(
  parameter int MAX_LAYERS  = cbe_pkg::DEF_MAX_LAYERS,
  parameter int MAX_SECTORS = cbe_pkg::DEF_MAX_SECTORS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input requests
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   mode_i,
  input  logic signed [31:0]           pos_x_i,
  input  logic signed [31:0]           pos_y_i,
  input  logic signed [31:0]           pos_z_i,
  input  logic [cbe_pkg::MH_W-1:0]     thickness_i,
  // results
  output logic                         empty,
  input  logic                         pop,
  output logic                         inside_res_o,
  output logic [cbe_pkg::IDX_W-1:0]    layer_index_o,
  output logic [cbe_pkg::IDX_W-1:0]    sector_index_o,
  output logic [cbe_pkg::DIST_W-1:0]   radial_distance_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbe_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cbe_pkg::*;

  // configuration registers
  logic [CNT_W-1:0] layer_count_q, sector_count_q;
  logic [MH_W-1:0]  max_height_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q  <= DEF_LAYER_COUNT;
      sector_count_q <= DEF_SECTOR_COUNT;
      max_height_q   <= DEF_MAX_HEIGHT;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LAYER_COUNT:  layer_count_q  <= pwdata[CNT_W-1:0];
        REG_SECTOR_COUNT: sector_count_q <= pwdata[CNT_W-1:0];
        REG_MAX_HEIGHT:   max_height_q   <= pwdata[MH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LAYER_COUNT:  prdata = 32'(layer_count_q);
      REG_SECTOR_COUNT: prdata = 32'(sector_count_q);
      REG_MAX_HEIGHT:   prdata = 32'(max_height_q);
      default:          prdata = '0;
    endcase
  end

  // front: classification
  logic   front_busy, init_busy, work_push, work_full, work_empty, work_pop;
  work_t  work_in, work_out;
  logic [$bits(work_t)-1:0] work_raw;

  assign full = front_busy || init_busy;

  cbe_front #(
    .MAX_LAYERS  (MAX_LAYERS),
    .MAX_SECTORS (MAX_SECTORS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (push && !full),
    .mode_i         (mode_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .thickness_i    (thickness_i),
    .layer_count_i  (layer_count_q),
    .sector_count_i (sector_count_q),
    .max_height_i   (max_height_q),
    .busy_o         (front_busy),
    .work_o         (work_in),
    .work_push_o    (work_push),
    .work_full_i    (work_full)
  );

  // queue between front and back
  cbe_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (2)
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (work_push),
    .data_i  (work_in),
    .full_o  (work_full),
    .pop_i   (work_pop),
    .data_o  (work_raw),
    .empty_o (work_empty)
  );

  assign work_out = work_t'(work_raw);

  // back: bin memory
  result_t res_in, res_out;
  logic    res_push, res_full;
  logic [$bits(result_t)-1:0] res_raw;

  cbe_back #(
    .MAX_LAYERS  (MAX_LAYERS),
    .MAX_SECTORS (MAX_SECTORS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_i       (work_out),
    .work_empty_i (work_empty),
    .work_pop_o   (work_pop),
    .res_o        (res_in),
    .res_push_o   (res_push),
    .res_full_i   (res_full),
    .init_busy_o  (init_busy)
  );

  // result queue
  cbe_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_raw),
    .empty_o (empty)
  );

  assign res_out           = result_t'(res_raw);
  assign inside_res_o      = res_out.inside_res;
  assign layer_index_o     = res_out.layer_index;
  assign sector_index_o    = res_out.sector_index;
  assign radial_distance_o = res_out.radial_distance;

endmodule

FILE: verif/cylindrical_bin_envelope_tb.sv
// ----------------------------------------------------------------------------
// cylindrical_bin_envelope_tb
// Self-checking bench: drives point requests through the push/full queue and
// config writes over APB, predicts every result with an in-bench copy of the
// bin store and binning arithmetic, and checks results as they are popped.
// ----------------------------------------------------------------------------
module cylindrical_bin_envelope_tb;
  import cbe_pkg::*;

  localparam int NBINS = DEF_MAX_LAYERS * DEF_MAX_SECTORS;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // request side
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        mode_i = MODE_CLEAR;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [MH_W-1:0]   thickness_i = '0;
  // result side
  logic              empty;
  logic              pop = 1'b0;
  logic              inside_res_o;
  logic [IDX_W-1:0]  layer_index_o, sector_index_o;
  logic [DIST_W-1:0] radial_distance_o;
  // config port
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  cylindrical_bin_envelope dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: shadow registers, bin store and ready flag
  logic [CNT_W-1:0]  layer_cnt_q  = DEF_LAYER_COUNT;
  logic [CNT_W-1:0]  sector_cnt_q = DEF_SECTOR_COUNT;
  logic [MH_W-1:0]   height_q     = DEF_MAX_HEIGHT;
  logic [31:0]       bin_max [NBINS] = '{default: '0};
  bit                built = 1'b0;

  result_t pending_results [$];
  int  errors = 0, requests_sent = 0, results_seen = 0, inside_hits = 0;
  int  queries_ready = 0, reach_hits = 0;
  bit  calm = 1'b0;  // no idling on either side while set

  localparam longint TURN_STEP [CORDIC_STEPS] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860, 10430,
    5215, 2608, 1304, 652, 326, 163, 81, 41, 20};

  // -------------------------------------------------------------------------
  // arithmetic of the block
  // -------------------------------------------------------------------------
  function automatic logic [31:0] isqrt(longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  // 16-bit turn of atan2(x, z) + pi; vector nonzero
  function automatic longint turn_angle(longint x, longint z);
    longint a = -z, b = -x, p, q, acc = 0, quad, np, nq;
    if (a > 0 && b >= 0) begin
      quad = 0; p = a; q = b;
    end else if (a <= 0 && b > 0) begin
      quad = 1; p = b; q = -a;
    end else if (a < 0 && b <= 0) begin
      quad = 2; p = -a; q = -b;
    end else begin
      quad = 3; p = -b; q = a;
    end
    while (p < (64'sd1 << 30) && q < (64'sd1 << 30)) begin
      p = p * 2;
      q = q * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      // arithmetic shift of a signed longint is a floor shift
      if (q >= 0) begin
        np = p + (q >>> i); nq = q - (p >>> i); acc = acc + TURN_STEP[i];
      end else begin
        np = p - (q >>> i); nq = q + (p >>> i); acc = acc - TURN_STEP[i];
      end
      p = np; q = nq;
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 22) - 1) acc = (64'sd1 << 22) - 1;
    return (quad * (64'sd1 << 22) + acc) >>> 8;
  endfunction

  // expected result of one accepted request; updates the shadow store
  function automatic result_t envelope_step(logic [1:0] m, logic signed [31:0] px,
                                            logic signed [31:0] py,
                                            logic signed [31:0] pz,
                                            logic [MH_W-1:0] th);
    result_t r = '0;
    longint x = px, y = py, z = pz, lc = layer_cnt_q, sc = sector_cnt_q, s;
    longint unsigned reach;
    longint layer = 0, sector = 0;
    logic [31:0] radial;
    if (m == MODE_CLEAR) begin
      foreach (bin_max[i]) bin_max[i] = '0;
      built = 1'b0;
      return r;
    end
    if (m == MODE_FINISH) begin
      built = 1'b1;
      return r;
    end
    // out-of-range counts behave as 1 or as the maximum
    if (lc == 0) lc = 1;
    if (lc > DEF_MAX_LAYERS) lc = DEF_MAX_LAYERS;
    if (sc == 0) sc = 1;
    if (sc > DEF_MAX_SECTORS) sc = DEF_MAX_SECTORS;
    if (y > 0) begin
      if (height_q == 0) layer = lc - 1;
      else begin
        s = (y * lc) / longint'(height_q);
        layer = (s >= lc) ? lc - 1 : s;
      end
    end
    if (x == 0 && z == 0) sector = 0;
    else if (x == 0 && z < 0) sector = sc - 1;
    else begin
      s = (turn_angle(x, z) * sc) >>> 16;
      sector = (s >= sc) ? sc - 1 : s;
    end
    radial = isqrt(longint'(x * x) + longint'(z * z));
    if (m == MODE_ACCUM) begin
      if (radial <= th) begin
        // thick enough to reach the axis: widen the whole layer
        reach_hits++;
        reach = longint'(radial) + longint'(th);
        if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
        for (int k = 0; k < sc; k++)
          if (bin_max[layer*DEF_MAX_SECTORS + k] < reach[31:0])
            bin_max[layer*DEF_MAX_SECTORS + k] = reach[31:0];
      end else if (bin_max[layer*DEF_MAX_SECTORS + sector] < radial) begin
        bin_max[layer*DEF_MAX_SECTORS + sector] = radial;
      end
    end else if (!built) begin
      r.inside_res = 1'b1;
    end else begin
      queries_ready++;
      r.inside_res = radial <= bin_max[layer*DEF_MAX_SECTORS + sector] &&
                     y <= longint'(height_q);
      inside_hits += r.inside_res;
    end
    r.layer_index     = layer[IDX_W-1:0];
    r.sector_index    = sector[IDX_W-1:0];
    r.radial_distance = radial;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // drivers
  // -------------------------------------------------------------------------
  // one request; push stays high afterwards so back-to-back sends never
  // lower and raise it in the same step
  task automatic send_request(logic [1:0] m, logic signed [31:0] px,
                              logic signed [31:0] py, logic signed [31:0] pz,
                              logic [MH_W-1:0] th);
    int gap;
    result_t want;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push = 1'b1;
    mode_i = m; pos_x_i = px; pos_y_i = py; pos_z_i = pz; thickness_i = th;
    do @(posedge clk_i); while (full);
    want = envelope_step(m, px, py, pz, th);
    pending_results.insert(pending_results.size(), want);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // stop sending and let every expected result come back
  task automatic drain;
    push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_LAYER_COUNT:  layer_cnt_q  = value[CNT_W-1:0];
      REG_SECTOR_COUNT: sector_cnt_q = value[CNT_W-1:0];
      REG_MAX_HEIGHT:   height_q     = value[MH_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_config(int lc, int sc, logic [31:0] mh);
    drain();
    reg_write(REG_LAYER_COUNT, lc);
    reg_write(REG_SECTOR_COUNT, sc);
    reg_write(REG_MAX_HEIGHT, mh);
  endtask

  // -------------------------------------------------------------------------
  // result checker: random pop stalls, field-by-field compare
  // -------------------------------------------------------------------------
  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  int pop_wait = 0;
  always @(negedge clk_i) begin
    if (!rst_ni || pop_wait > 0) begin
      pop <= 1'b0;
      if (rst_ni) pop_wait <= pop_wait - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      pop_wait <= calm ? 0 : $urandom_range(0, 4);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got distance %0d", $time,
                 radial_distance_o);
      end else begin
        want = pending_results.pop_front();
        check_field("inside_res", want.inside_res, inside_res_o);
        check_field("layer_index", want.layer_index, layer_index_o);
        check_field("sector_index", want.sector_index, sector_index_o);
        check_field("radial_distance", want.radial_distance, radial_distance_o);
      end
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------
  function automatic logic signed [31:0] rand_coord();
    int r = 20 * 65536;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: case ($urandom_range(0, 4))
           0: return 32'sh8000_0000;
           1: return 32'sh7FFF_FFFF;
           2: return 0;
           3: return -1;
           default: return 1;
         endcase
      default: return $signed($urandom_range(0, 2 * r)) - r;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_height();
    longint h = height_q;
    longint top;
    top = (h + h / 8 > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : h + h / 8;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return -$signed($urandom_range(0, 65536));
      default: return $urandom_range(0, 32'(top));
    endcase
  endfunction

  function automatic logic [MH_W-1:0] rand_thickness();
    case ($urandom_range(0, 9))
      0: return MH_W'($urandom);
      1: return '1;
      2: return '0;
      3: return MH_W'($urandom_range(10 * 65536, 40 * 65536));  // usually reaches axis
      default: return MH_W'($urandom_range(0, 2 * 65536));
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------
  // query before build, axis point, angle at pi, coordinate extremes,
  // heights below zero and above the envelope, build and query, clear and query
  task automatic test_directed;
    send_request(MODE_QUERY, 32'sd65536, 32'sd65536, 32'sd65536, '0);
    send_request(MODE_ACCUM, 0, 0, 0, '0);
    send_request(MODE_ACCUM, 0, 32'sd100000, -32'sd300000, '0);
    send_request(MODE_ACCUM, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, '0);
    send_request(MODE_ACCUM, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, '1);
    send_request(MODE_ACCUM, 32'sd65536, -32'sd5, 0, 31'd131072);
    send_request(MODE_ACCUM, -32'sd200000, 32'sd300000, 32'sd150000, 31'd1);
    send_request(MODE_ACCUM, 32'sd400000, 32'sd655360, -32'sd1, '0);
    send_request(MODE_FINISH, 32'sd7, -32'sd7, 32'sd7, '1);
    send_request(MODE_QUERY, -32'sd200000, 32'sd300000, 32'sd150000, '0);
    send_request(MODE_QUERY, -32'sd200001, 32'sd300000, 32'sd150001, '0);
    send_request(MODE_QUERY, 32'sd65536, 32'sd655361, 0, '0);
    send_request(MODE_QUERY, 0, 0, 0, '0);
    send_request(MODE_QUERY, 0, 32'sd1, -32'sd1, '0);
    send_request(MODE_ACCUM, 32'sd900000, 32'sd10, 32'sd10, '0);  // after finish
    send_request(MODE_QUERY, 32'sd900000, 32'sd10, 32'sd10, '0);
    send_request(MODE_QUERY, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0);
    send_request(MODE_CLEAR, 32'sd3, 32'sd3, 32'sd3, '1);
    send_request(MODE_QUERY, 32'sd5, 32'sd5, 32'sd5, '0);
    drain();
  endtask

  // counts out of range, zero height, smallest and largest settings
  task automatic test_config_extremes;
    set_config(0, 127, 0);
    send_request(MODE_ACCUM, 32'sd70000, 32'sd1, -32'sd9000, '0);
    send_request(MODE_ACCUM, -32'sd3, -32'sd1, 32'sd3, '1);
    send_request(MODE_FINISH, 0, 0, 0, '0);
    send_request(MODE_QUERY, 32'sd70000, 32'sd1, -32'sd9000, '0);
    set_config(64, 64, 32'h7FFF_FFFF);
    send_request(MODE_ACCUM, 32'sd123456, 32'sh7FFF_FFFF, -32'sd654321, '0);
    send_request(MODE_QUERY, 32'sd123456, 32'sh7FFF_FFFF, -32'sd654321, '0);
    set_config(1, 1, 1);
    send_request(MODE_QUERY, 32'sd1, 32'sd2, 32'sd1, '0);
    send_request(MODE_CLEAR, 0, 0, 0, '0);
    drain();
  endtask

  // build/query phases with random content, varied settings, some noise
  task automatic test_random_builds(int budget);
    int stop_at = requests_sent + budget, n;
    logic [1:0] m;
    while (requests_sent < stop_at) begin
      case ($urandom_range(0, 5))
        0: set_config(1, 64, $urandom_range(1, 32'h7FFF_FFFF));
        1: set_config($urandom_range(1, 64), $urandom_range(1, 64),
                      $urandom_range(65536, 64 * 65536));
        2: set_config($urandom_range(0, 127), $urandom_range(0, 127), $urandom);
        default: drain();  // hold off until every result is back
      endcase
      calm = ($urandom_range(0, 3) == 0);
      send_request(MODE_CLEAR, rand_coord(), rand_coord(), rand_coord(), rand_thickness());
      n = $urandom_range(10, 40);
      repeat (n) send_request(MODE_ACCUM, rand_coord(), rand_height(), rand_coord(),
                              rand_thickness());
      send_request(MODE_FINISH, rand_coord(), rand_coord(), rand_coord(), rand_thickness());
      n = $urandom_range(10, 40);
      repeat (n) begin
        m = ($urandom_range(0, 9) == 0) ? mode_e'($urandom_range(1, 3)) : MODE_QUERY;
        send_request(m, rand_coord(), rand_height(), rand_coord(), rand_thickness());
      end
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_config_extremes();
    test_random_builds(1000);
    repeat (50) @(negedge clk_i);
    $display("%0d requests, %0d results; %0d built queries (%0d inside), %0d axis reaches",
             requests_sent, results_seen, queries_ready, inside_hits, reach_hits);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("cylindrical_bin_envelope_tb passed");
    end else begin
      $display("cylindrical_bin_envelope_tb failed");
    end
    $finish;
  end

  // watchdog: clear sweeps dominate; several times the slowest expected run
  initial begin
    #50_000_000;
    $display("cylindrical_bin_envelope_tb failed");
    $finish;
  end

endmodule
